@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file of the cache block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising clk edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/core/lkv_pkg.sv @@
// Shared constants, types and codes of the LRU key-value cache.
`default_nettype none
package lkv_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 16;
  localparam int VAL_W   = 16;
  localparam int CAP_W   = 5;
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic             load;
    logic [IDX_W-1:0] upto;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } cell_ctl_t;

endpackage
`default_nettype wire

@@ rtl/core/lkv_cell.sv @@
// One recency cell: holds a key/value pair, compares and shifts toward the back.
`default_nettype none
module lkv_cell import lkv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  cell_ctl_t        ctl,
  input  logic [KEY_W-1:0] prev_key,
  input  logic [VAL_W-1:0] prev_value,
  input  logic             prev_valid,
  output logic [KEY_W-1:0] key_r,
  output logic [VAL_W-1:0] value_r,
  output logic             valid_r,
  output logic             match
);

  logic is_front;
  logic take_prev;

  assign is_front  = (cell_idx == '0);
  assign take_prev = ctl.load && !is_front && (cell_idx <= ctl.upto);
  assign match     = valid_r && (key_r == ctl.key);

  // Track occupancy of this slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.load && is_front) begin
      valid_r <= 1'b1;
    end else if (take_prev) begin
      valid_r <= prev_valid;
    end
  end

  // Load the front pair or take the neighbor's pair
  always_ff @(posedge clk) begin
    if (ctl.load && is_front) begin
      key_r   <= ctl.key;
      value_r <= ctl.value;
    end else if (take_prev) begin
      key_r   <= prev_key;
      value_r <= prev_value;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/lkv_sel.sv @@
// Match encoder: turns the one-hot match row into hit, position and stored value.
`default_nettype none
module lkv_sel import lkv_pkg::*; (
  input  logic [ENTRIES-1:0]            match,
  input  logic [ENTRIES-1:0][VAL_W-1:0] values,
  output logic                          hit,
  output logic [IDX_W-1:0]              pos,
  output logic [VAL_W-1:0]              stored
);

  // OR together index and value of the single matching cell
  always_comb begin
    pos    = '0;
    stored = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) begin
        pos    = pos | IDX_W'(i);
        stored = stored | values[i];
      end
    end
  end

  assign hit = |match;

endmodule
`default_nettype wire

@@ rtl/core/lru_key_value_cache.sv @@
// Top level of the LRU key-value cache: controller, recency cell chain, result register.
//
//   channel | direction | ports                                   | handshake
//   in      | input     | in_func, in_key, in_value               | in_valid / in_stall
//   out     | output    | out_hit, out_read_value, out_evicted    | out_valid / out_stall
//   cfg     | input     | cfg_wr_data (capacity limit)            | cfg_wr_en
//
// An input word passes a compare state, which compares the key against every cell and
// registers the match, then an update state, which shifts the cell chain and loads the result register.
// A new word is taken in the update state, never in the compare state.
// Reset (rst_n low at a clk edge) empties all cells and sets the capacity to 16.
// A stall on out holds the shift cycle only while the result register is full.
`default_nettype none
module lru_key_value_cache import lkv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_func,
  input  logic [KEY_W-1:0] in_key,
  input  logic [VAL_W-1:0] in_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_hit,
  output logic [VAL_W-1:0] out_read_value,
  output logic             out_evicted,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data
);

  state_t state_r, state_nxt;

  logic [CAP_W-1:0] cap_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic             op_func_r;
  logic [KEY_W-1:0] op_key_r;
  logic [VAL_W-1:0] op_value_r;

  logic             hit_r;
  logic [IDX_W-1:0] pos_r;
  logic [VAL_W-1:0] stored_r;

  logic             out_valid_r;
  logic             out_hit_r;
  logic [VAL_W-1:0] out_read_value_r;
  logic             out_evicted_r;

  logic in_fire, out_fire, out_free, upd_fire;
  logic is_get_hit, is_put_miss, evict;

  logic [CMP_W-1:0] cap_eff;
  logic [CMP_W-1:0] count_ext;

  cell_ctl_t ctl;

  logic [ENTRIES-1:0]            match;
  logic [ENTRIES-1:0][KEY_W-1:0] cell_key;
  logic [ENTRIES-1:0][VAL_W-1:0] cell_value;
  logic [ENTRIES-1:0]            cell_valid;

  logic             sel_hit;
  logic [IDX_W-1:0] sel_pos;
  logic [VAL_W-1:0] sel_stored;

  // Handshakes
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r == ST_CMP) || ((state_r == ST_UPD) && !out_free);
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;
  assign upd_fire = (state_r == ST_UPD) && out_free;

  // Sequence compare and update
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_UPD;
      ST_UPD:  begin
        if (in_fire) begin
          state_nxt = ST_CMP;
        end else if (upd_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  // Latch the accepted word
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_func_r  <= in_func;
      op_key_r   <= in_key;
      op_value_r <= in_value;
    end
  end

  // Register the compare result
  always_ff @(posedge clk) begin
    if (state_r == ST_CMP) begin
      hit_r    <= sel_hit;
      pos_r    <= sel_pos;
      stored_r <= sel_stored;
    end
  end

  // Clamp the capacity to one through the cell count and decide eviction
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CMP_W'(1);
    end else if (CMP_W'(cap_r) > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end else begin
      cap_eff = CMP_W'(cap_r);
    end
  end

  assign count_ext   = CMP_W'(count_r);
  assign evict       = (count_ext >= cap_eff);
  assign is_get_hit  = hit_r && (op_func_r == FUNC_GET);
  assign is_put_miss = !hit_r && (op_func_r == FUNC_PUT);

  // Drive the cell chain
  always_comb begin
    ctl.key   = op_key_r;
    ctl.value = is_get_hit ? stored_r : op_value_r;
    ctl.load  = upd_fire && (hit_r || is_put_miss);
    if (hit_r) begin
      ctl.upto = pos_r;
    end else if (evict) begin
      ctl.upto = IDX_W'(count_r - CNT_W'(1));
    end else begin
      ctl.upto = IDX_W'(count_r);
    end
  end

  // Grow occupancy on a new key that needs no eviction
  always_comb begin
    count_nxt = count_r;
    if (upd_fire && is_put_miss && !evict) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Recency chain, front at cell 0
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    logic [KEY_W-1:0] prev_key;
    logic [VAL_W-1:0] prev_value;
    logic             prev_valid;

    if (g == 0) begin : g_front
      assign prev_key   = '0;
      assign prev_value = '0;
      assign prev_valid = 1'b0;
    end else begin : g_link
      assign prev_key   = cell_key[g-1];
      assign prev_value = cell_value[g-1];
      assign prev_valid = cell_valid[g-1];
    end

    lkv_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_idx   (IDX_W'(g)),
      .ctl        (ctl),
      .prev_key   (prev_key),
      .prev_value (prev_value),
      .prev_valid (prev_valid),
      .key_r      (cell_key[g]),
      .value_r    (cell_value[g]),
      .valid_r    (cell_valid[g]),
      .match      (match[g])
    );
  end

  lkv_sel u_sel (
    .match  (match),
    .values (cell_value),
    .hit    (sel_hit),
    .pos    (sel_pos),
    .stored (sel_stored)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      out_hit_r        <= hit_r;
      out_read_value_r <= is_get_hit ? stored_r : '0;
      out_evicted_r    <= is_put_miss && evict;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_read_value_r;
  assign out_evicted    = out_evicted_r;

endmodule
`default_nettype wire

@@ rtl/core/lkv_checker.sv @@
// Port-level checker for the LRU key-value cache and its bind statement.
`default_nettype none
`include "assert_macros.svh"
module lkv_checker import lkv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic             out_hit,
  input  logic [VAL_W-1:0] out_read_value,
  input  logic             out_evicted
);

  // Hold a stalled result word
  `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid, "out word dropped under stall")

  // Space accepted words by the compare cycle
  `ASSERT_CLK(a_in_gap, in_valid && !in_stall |=> in_stall, "input word taken in compare cycle")

  // Return a value only on a hit
  `ASSERT_CLK(a_value_hit, out_valid |-> (out_read_value == '0 || out_hit), "value without hit")

  // Evict only on a miss
  `ASSERT_NEVER(a_evict_hit, out_valid && out_hit && out_evicted, "eviction on a hit")

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (.*);
`default_nettype wire

@@ sim/lkv_result_monitor.sv @@
`timescale 1ns / 1ps
// Result monitor of the LRU key-value cache: recency predictor and per-field compare.
module lkv_result_monitor import lkv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic             in_func,
  input  logic [KEY_W-1:0] in_key,
  input  logic [VAL_W-1:0] in_value,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic             out_hit,
  input  logic [VAL_W-1:0] out_read_value,
  input  logic             out_evicted,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data,
  output int               outstanding,
  output int               mismatch_total
);

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
  } answer_t;

  // Shadow store: slot 0 is the most recently used entry.
  logic [KEY_W-1:0] slot_key   [ENTRIES];
  logic [VAL_W-1:0] slot_value [ENTRIES];
  int               occupancy;
  logic [CAP_W-1:0] capacity;
  answer_t          answers_due[$];
  int               errors = 0;

  task automatic report_mismatch(string what);
    $display("%0t ns: %s", $time, what);
    errors++;
  endtask

  // Apply one access to the shadow store and return the answer it gives.
  function automatic answer_t lru_access(logic func, logic [KEY_W-1:0] key,
                                         logic [VAL_W-1:0] value);
    answer_t          ans;
    int               pos;
    int               limit;
    int               top;
    logic [VAL_W-1:0] stored;
    ans   = '0;
    pos   = -1;
    limit = (capacity == 0) ? 1 : ((capacity > ENTRIES) ? ENTRIES : int'(capacity));
    for (int i = 0; i < occupancy; i++)
      if (pos < 0 && slot_key[i] == key) pos = i;

    if (pos >= 0) begin
      // Hit: pull the entry to the front.
      stored  = slot_value[pos];
      ans.hit = 1'b1;
      for (int i = pos; i > 0; i--) begin
        slot_key[i]   = slot_key[i-1];
        slot_value[i] = slot_value[i-1];
      end
      slot_key[0] = key;
      if (func == FUNC_GET) begin
        ans.read_value = stored;
        slot_value[0]  = stored;
      end else begin
        slot_value[0] = value;
      end
    end else if (func == FUNC_PUT) begin
      // Miss on a write: drop the oldest entry when full, then insert at the front.
      if (occupancy >= limit) begin
        ans.evicted = 1'b1;
        occupancy--;
      end
      top = (occupancy < ENTRIES) ? occupancy : ENTRIES - 1;
      for (int i = top; i > 0; i--) begin
        slot_key[i]   = slot_key[i-1];
        slot_value[i] = slot_value[i-1];
      end
      slot_key[0]   = key;
      slot_value[0] = value;
      occupancy++;
    end
    return ans;
  endfunction

  // Compare each accepted result word first, then predict the accepted input word.
  always @(posedge clk) begin
    answer_t due;
    if (!rst_n) begin
      occupancy = 0;
      capacity  = CAP_RESET;
      answers_due.delete();
    end else begin
      if (cfg_wr_en) capacity = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          report_mismatch($sformatf("result word with nothing awaited: hit %b value %h evicted %b",
                                    out_hit, out_read_value, out_evicted));
        end else begin
          due = answers_due.pop_front();
          if (out_hit !== due.hit)
            report_mismatch($sformatf("hit is %b, expected %b", out_hit, due.hit));
          if (out_read_value !== due.read_value)
            report_mismatch($sformatf("read_value is %h, expected %h",
                                      out_read_value, due.read_value));
          if (out_evicted !== due.evicted)
            report_mismatch($sformatf("evicted is %b, expected %b", out_evicted, due.evicted));
        end
      end
      if (in_valid && !in_stall)
        answers_due.push_back(lru_access(in_func, in_key, in_value));
    end
    outstanding    <= answers_due.size();
    mismatch_total <= errors;
  end

endmodule

@@ sim/tb_lru_key_value_cache.sv @@
`timescale 1ns / 1ps
// Testbench top of the LRU key-value cache: stimulus, flow control and verdict.
module tb_lru_key_value_cache;
  import lkv_pkg::*;

  localparam int CLK_PERIOD      = 8;
  localparam int WATCHDOG_CYCLES = 5000;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 6;
  localparam int PHASES          = 10;
  localparam int PHASE_WORDS     = 124;

  logic             clk            = 1'b0;
  logic             rst_n          = 1'b0;
  logic             in_valid       = 1'b0;
  logic             in_func        = FUNC_GET;
  logic [KEY_W-1:0] in_key         = '0;
  logic [VAL_W-1:0] in_value       = '0;
  logic             out_stall      = 1'b0;
  logic             cfg_wr_en      = 1'b0;
  logic [CAP_W-1:0] cfg_wr_data    = CAP_RESET;
  logic             in_stall;
  logic             out_valid;
  logic             out_hit;
  logic [VAL_W-1:0] out_read_value;
  logic             out_evicted;

  int               awaited;
  int               fail_total;
  int               words_sent  = 0;
  int               idle_cycles = 0;
  int               burst_left  = 0;
  logic [KEY_W-1:0] pool_base;
  int               pool_span;

  always #(CLK_PERIOD / 2) clk = ~clk;

  lru_key_value_cache dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  lkv_result_monitor monitor (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .outstanding    (awaited),
    .mismatch_total (fail_total)
  );

  // Abort when no word moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("lru_key_value_cache verification failed");
      $finish;
    end
  end

  // Offer one word and hold it until the block takes it.
  task automatic send_word(logic func, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
    in_valid <= 1'b1;
    in_func  <= func;
    in_key   <= key;
    in_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // Drop valid for a random gap; a zero gap keeps the burst going.
  task automatic pause_sender();
    int gap;
    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
    if (gap > 0) begin
      if (in_valid) in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait for every awaited result plus the pipeline depth.
  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Random accesses over a key pool at least as large as the capacity in use.
  task automatic random_phase(int count, int usable);
    logic             func;
    logic [KEY_W-1:0] key;
    pool_base = KEY_W'($urandom);
    pool_span = usable + $urandom_range(0, 4);
    for (int n = 0; n < count; n++) begin
      if (burst_left == 0) begin
        pause_sender();
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      func = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) key = KEY_W'($urandom);
      else key = pool_base ^ KEY_W'($urandom_range(0, pool_span - 1));
      send_word(func, key, VAL_W'($urandom));
    end
  endtask

  // Receiver: stall patterns in segments, plus long hold-offs to fill the block.
  initial begin
    int mode;
    int span;
    int holds;
    holds = 0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (holds < 2 && words_sent >= 300 + 500 * holds) begin
        holds++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 80);
      for (int k = 0; k < span; k++) begin
        case (mode)
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          3: out_stall <= k[0];
          default: out_stall <= 1'b0;
        endcase
        @(posedge clk);
      end
    end
  end

  // Stimulus: reset, directed accesses, then random phases over several capacities.
  initial begin
    logic [CAP_W-1:0] cap;
    int               usable;
    logic [CAP_W-1:0] cap_plan [7];
    cap_plan = '{5'd31, 5'd1, 5'd16, 5'd4, 5'd0, 5'd17, 5'd2};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty store, key and value extremes, update in place, lookup miss.
    send_word(FUNC_GET, 16'h0000, 16'hFFFF);
    send_word(FUNC_PUT, 16'h0000, 16'hFFFF);
    send_word(FUNC_PUT, 16'hFFFF, 16'h0000);
    send_word(FUNC_GET, 16'h0000, 16'h0000);
    send_word(FUNC_GET, 16'hFFFF, 16'hFFFF);
    send_word(FUNC_PUT, 16'hFFFF, 16'h1234);
    send_word(FUNC_GET, 16'h0007, 16'h0000);
    drain();

    // Capacity zero acts as one and sits below the two entries held.
    write_capacity(5'd0);
    send_word(FUNC_GET, 16'h0000, 16'h0000);
    send_word(FUNC_PUT, 16'h0009, 16'h0005);
    send_word(FUNC_GET, 16'hFFFF, 16'h0000);
    send_word(FUNC_GET, 16'h0009, 16'h0000);
    send_word(FUNC_PUT, 16'h0000, 16'hAAAA);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      cap    = (ph < 7) ? cap_plan[ph] : CAP_W'($urandom_range(0, 31));
      usable = (cap == 0) ? 1 : ((cap > ENTRIES) ? ENTRIES : int'(cap));
      write_capacity(cap);
      random_phase(PHASE_WORDS, usable);
      drain();
    end

    if (fail_total == 0 && awaited == 0) begin
      $display("lru_key_value_cache verification clean");
    end else begin
      $display("lru_key_value_cache verification failed");
    end
    $finish;
  end

endmodule
